// File: hdl/ga_fitness_tally_tournament_assert.svh
// assertion macros used by the checker file
`ifndef GA_FITNESS_TALLY_TOURNAMENT_ASSERT_SVH
`define GA_FITNESS_TALLY_TOURNAMENT_ASSERT_SVH

// same-cycle implication
`define GAFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gaft assertion failed");

// next-cycle implication
`define GAFT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gaft assertion failed");

`endif

// File: hdl/gaft_pkg.sv
// package: sizes, codes, states and payload types of the fitness tally block
`default_nettype none

package gaft_pkg;

	localparam int INDIVIDUALS = 128;
	localparam int IDX_W = $clog2(INDIVIDUALS);
	localparam int PTR_W = IDX_W + 1;
	localparam int SUM_W = IDX_W + 9;

	localparam logic [7:0] SCORE_MAX = 8'hFF;
	localparam logic [7:0] TARGET_RESET = 8'd16;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_TALLY = 2'd1;
	localparam logic [1:0] MODE_REPORT = 2'd2;
	localparam logic [1:0] MODE_CONTEND = 2'd3;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_WINNER = 1'b1;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_TALLY_RD,
		ST_TALLY_WR,
		ST_REP_SCAN,
		ST_REP_DIV,
		ST_CT_MOD,
		ST_CT_RD_A,
		ST_CT_RD_B,
		ST_CT_CMP,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  group;
		logic [31:0] match_word;
		logic [6:0]  contender;
		logic        last_contender;
	} item_t;

	typedef struct packed {
		logic       kind;
		logic [6:0] fittest_index;
		logic [7:0] fittest_score;
		logic [6:0] least_index;
		logic [7:0] least_score;
		logic [7:0] average_score;
		logic       solved;
		logic [6:0] winner_index;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/gaft_ram.sv
// generic single-port ram with registered read
`default_nettype none

module gaft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: hdl/ga_fitness_tally_tournament.sv
// Fitness tally and tournament selection block, the top level.
// Scores live in a single-port RAM of INDIVIDUALS bytes and every item is
// worked by a small sequencer around that one port, so item_stall is high
// for the whole of an item. After reset and on each clear item the block
// sweeps zeros through the RAM, one entry a cycle. A tally item reads and
// writes back each of four scores in turn. A report item scans the RAM,
// takes the average as the sum shifted down by log2 of INDIVIDUALS (a power
// of two) and then loads the result register. A contender item takes only
// the modulo step when it opens a tournament, and otherwise goes on to two
// RAM reads and a compare; the modulo step repeats while the index is out
// of range, and a further step loads a winner. Results wait in an output
// register, so the next item is taken while a result is still stalled; an
// item with a result holds in its last step until that register is free.
`default_nettype none

module ga_fitness_tally_tournament
	import gaft_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result,
	input  wire logic    cfg_valid,
	output logic         cfg_ready,
	input  wire logic [7:0] cfg_data
);

	function automatic logic [3:0] popcnt8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(b[i]);
		end
		return n;
	endfunction

	function automatic logic [6:0] idx7(input logic [IDX_W-1:0] i);
		logic [31:0] w;
		w = 32'(i);
		return w[6:0];
	endfunction

	st_t st_q, st_d;

	logic [4:0]       group_q;
	logic [31:0]      word_q;
	logic [6:0]       cont_q;
	logic             last_q;
	logic             kind_q;
	logic [1:0]       k_q;
	logic [PTR_W-1:0] ptr_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [7:0]       hi_score_q, lo_score_q;
	logic [IDX_W-1:0] hi_idx_q, lo_idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [7:0]       avg_q;
	logic [IDX_W-1:0] best_q;
	logic             open_q;
	logic [7:0]       cand_q;
	logic [7:0]       target_q;
	logic             result_valid_q;
	result_t          result_q;

	logic [IDX_W-1:0] ram_addr;
	logic             ram_we;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	logic             item_take;
	logic             result_free;
	logic [6:0]       tally_idx;
	logic             tally_ok;
	logic [8:0]       tally_sum;
	logic [7:0]       tally_new;
	logic             ptr_end;
	logic             sweep_last;
	logic             cont_big;
	result_t          result_d;

	gaft_ram #(
		.WIDTH(8),
		.DEPTH(INDIVIDUALS)
	) u_score_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign item_take   = item_valid && !item_stall;
	assign result_free = !result_valid_q || !result_stall;
	assign tally_idx   = {group_q, k_q};
	assign tally_ok    = 32'(tally_idx) < 32'(INDIVIDUALS);
	assign tally_sum   = {1'b0, ram_rdata} + 9'(popcnt8(word_q[{k_q, 3'b000} +: 8]));
	assign tally_new   = tally_sum[8] ? SCORE_MAX : tally_sum[7:0];
	assign ptr_end     = ptr_q == PTR_W'(INDIVIDUALS);
	assign sweep_last  = ptr_q == PTR_W'(INDIVIDUALS - 1);
	assign cont_big    = 32'(cont_q) >= 32'(INDIVIDUALS);

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_SWEEP: begin
				if (sweep_last) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_take) begin
					unique case (item.mode)
						MODE_CLEAR:   st_d = ST_SWEEP;
						MODE_TALLY:   st_d = ST_TALLY_RD;
						MODE_REPORT:  st_d = ST_REP_SCAN;
						MODE_CONTEND: st_d = ST_CT_MOD;
						default:      st_d = ST_IDLE;
					endcase
				end
			end
			ST_TALLY_RD: st_d = ST_TALLY_WR;
			ST_TALLY_WR: begin
				if (k_q == 2'd3) begin
					st_d = ST_IDLE;
				end else begin
					st_d = ST_TALLY_RD;
				end
			end
			ST_REP_SCAN: begin
				if (ptr_end && !rd_vld_s1) begin
					st_d = ST_REP_DIV;
				end
			end
			ST_REP_DIV: st_d = ST_EMIT;
			ST_CT_MOD: begin
				if (!cont_big) begin
					if (open_q) begin
						st_d = ST_CT_RD_A;
					end else if (last_q) begin
						st_d = ST_EMIT;
					end else begin
						st_d = ST_IDLE;
					end
				end
			end
			ST_CT_RD_A: st_d = ST_CT_RD_B;
			ST_CT_RD_B: st_d = ST_CT_CMP;
			ST_CT_CMP: begin
				if (last_q) begin
					st_d = ST_EMIT;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (result_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item_stall = 1'b1;
		ram_addr   = '0;
		ram_we     = 1'b0;
		ram_wdata  = 8'd0;
		unique case (st_q)
			ST_SWEEP: begin
				ram_addr = ptr_q[IDX_W-1:0];
				ram_we   = 1'b1;
			end
			ST_IDLE: item_stall = 1'b0;
			ST_TALLY_RD: ram_addr = IDX_W'(tally_idx);
			ST_TALLY_WR: begin
				ram_addr  = IDX_W'(tally_idx);
				ram_we    = tally_ok;
				ram_wdata = tally_new;
			end
			ST_REP_SCAN: ram_addr = ptr_q[IDX_W-1:0];
			ST_CT_RD_A: ram_addr = IDX_W'(cont_q);
			ST_CT_RD_B: ram_addr = best_q;
			ST_REP_DIV, ST_CT_MOD, ST_CT_CMP, ST_EMIT: begin
				ram_addr = '0;
			end
			default: item_stall = 1'b1;
		endcase
	end

	always_comb begin
		result_d = '0;
		result_d.kind = kind_q;
		if (kind_q == KIND_WINNER) begin
			result_d.winner_index = idx7(best_q);
		end else begin
			result_d.fittest_index = idx7(hi_idx_q);
			result_d.fittest_score = hi_score_q;
			result_d.least_index   = idx7(lo_idx_q);
			result_d.least_score   = lo_score_q;
			result_d.average_score = avg_q;
			result_d.solved        = hi_score_q == target_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_SWEEP;
			ptr_q          <= '0;
			k_q            <= 2'd0;
			rd_vld_s1      <= 1'b0;
			best_q         <= '0;
			open_q         <= 1'b0;
			target_q       <= TARGET_RESET;
			result_valid_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			rd_vld_s1 <= (st_q == ST_REP_SCAN) && !ptr_end;
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end
			if (st_q == ST_EMIT && result_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_SWEEP: ptr_q <= ptr_q + 1'b1;
				ST_IDLE: begin
					if (item_take) begin
						ptr_q <= '0;
						k_q   <= 2'd0;
					end
				end
				ST_TALLY_WR: k_q <= k_q + 1'b1;
				ST_REP_SCAN: begin
					if (!ptr_end) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_CT_MOD: begin
					if (!cont_big && !open_q) begin
						best_q <= IDX_W'(cont_q);
						open_q <= !last_q;
					end
				end
				ST_CT_CMP: begin
					if (cand_q > ram_rdata) begin
						best_q <= IDX_W'(cont_q);
					end
					open_q <= !last_q;
				end
				ST_TALLY_RD, ST_REP_DIV, ST_CT_RD_A, ST_CT_RD_B, ST_EMIT: begin
					open_q <= open_q;
				end
				default: open_q <= open_q;
			endcase
		end
	end

	// payload and datapath
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q[IDX_W-1:0];
		if (st_q == ST_IDLE && item_take) begin
			group_q <= item.group;
			word_q  <= item.match_word;
			cont_q  <= item.contender;
			last_q  <= item.last_contender;
			kind_q  <= (item.mode == MODE_CONTEND) ? KIND_WINNER : KIND_REPORT;
		end
		if (st_q == ST_CT_MOD && cont_big) begin
			cont_q <= cont_q - 7'(INDIVIDUALS);
		end
		if (st_q == ST_CT_RD_B) begin
			cand_q <= ram_rdata;
		end
		// scan of returned scores
		if (rd_vld_s1) begin
			if (rd_idx_s1 == '0) begin
				hi_score_q <= ram_rdata;
				lo_score_q <= ram_rdata;
				hi_idx_q   <= '0;
				lo_idx_q   <= '0;
				sum_q      <= SUM_W'(ram_rdata);
			end else begin
				if (ram_rdata > hi_score_q) begin
					hi_score_q <= ram_rdata;
					hi_idx_q   <= rd_idx_s1;
				end
				if (ram_rdata < lo_score_q) begin
					lo_score_q <= ram_rdata;
					lo_idx_q   <= rd_idx_s1;
				end
				sum_q <= sum_q + SUM_W'(ram_rdata);
			end
		end
		// average is the sum shifted down by log2 of the population size
		if (st_q == ST_REP_DIV) begin
			avg_q <= sum_q[IDX_W +: 8];
		end
		if (st_q == ST_EMIT && result_free) begin
			result_q <= result_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/gaft_chk.sv
// port-level checker for the fitness tally block and its bind
`default_nettype none

`include "ga_fitness_tally_tournament_assert.svh"

module gaft_chk
	import gaft_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	`GAFT_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))
	`GAFT_ASSERT_NXT(a_item_busy, clk, arst_n, item_valid && !item_stall, item_stall)
	`GAFT_ASSERT_IMP(a_winner_clean, clk, arst_n, result_valid && result.kind == KIND_WINNER, result.fittest_score == 8'd0 && result.least_score == 8'd0 && result.average_score == 8'd0 && !result.solved)
	`GAFT_ASSERT_IMP(a_report_order, clk, arst_n, result_valid && result.kind == KIND_REPORT, result.least_score <= result.average_score && result.average_score <= result.fittest_score && result.winner_index == 7'd0)

endmodule

bind ga_fitness_tally_tournament gaft_chk u_gaft_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire

// File: test/ga_fitness_tally_tournament_test.sv
// testbench for the fitness tally and tournament block: directed table, then random phases
`timescale 1ns / 100ps

module ga_fitness_tally_tournament_test
	import gaft_pkg::*;
();

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 255;
	localparam int SETTLE_CYCLES = 200;
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		item_t   stim;
		bit      typed;
		result_t want;
	} drill_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	item_t      offered = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	// predictor state
	logic [7:0] fitness [INDIVIDUALS];
	int         champion;
	bit         bracket_open;
	logic [7:0] target;

	result_t awaited_results [$];
	int      bracket_left;
	bit      quiet;
	bit      hold_req;
	int      failures;
	int      items_sent;
	int      reports_seen;
	int      winners_seen;
	int      solved_seen;
	int      saturated_seen;
	int      settings_written;
	int      idle_cycles;

	ga_fitness_tally_tournament dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (offered),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit tally_rank(input item_t it, output result_t res);
		int idx;
		int s;
		int hi;
		int lo;
		int sum;
		int c;
		res = '0;
		case (it.mode)
			MODE_CLEAR: begin
				foreach (fitness[p]) fitness[p] = '0;
				return 1'b0;
			end
			MODE_TALLY: begin
				for (int k = 0; k < 4; k++) begin
					idx = int'(it.group) * 4 + k;
					if (idx < INDIVIDUALS) begin
						s = int'(fitness[idx]) + $countones(it.match_word[8*k +: 8]);
						fitness[idx] = (s > int'(SCORE_MAX)) ? SCORE_MAX : s[7:0];
					end
				end
				return 1'b0;
			end
			MODE_REPORT: begin
				hi = 0;
				lo = 0;
				sum = 0;
				for (int p = 0; p < INDIVIDUALS; p++) begin
					if (fitness[p] > fitness[hi]) hi = p;
					if (fitness[p] < fitness[lo]) lo = p;
					sum += fitness[p];
				end
				res.kind = KIND_REPORT;
				res.fittest_index = hi[6:0];
				res.fittest_score = fitness[hi];
				res.least_index = lo[6:0];
				res.least_score = fitness[lo];
				res.average_score = 8'(sum / INDIVIDUALS);
				res.solved = (fitness[hi] == target);
				return 1'b1;
			end
			default: begin
				c = int'(it.contender) % INDIVIDUALS;
				if (!bracket_open || champion >= INDIVIDUALS) begin
					champion = c;
					bracket_open = 1'b1;
				end else if (fitness[c] > fitness[champion]) begin
					champion = c;
				end
				if (it.last_contender) begin
					res.kind = KIND_WINNER;
					res.winner_index = champion[6:0];
					bracket_open = 1'b0;
					return 1'b1;
				end
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic [7:0] peak_score();
		logic [7:0] m;
		m = '0;
		foreach (fitness[p]) if (fitness[p] > m) m = fitness[p];
		return m;
	endfunction

	function automatic drill_t drill(logic [1:0] mode, int grp, logic [31:0] word, int cont,
			bit last, bit typed = 1'b0, result_t want = '0);
		drill_t d;
		d.stim.mode = mode;
		d.stim.group = grp[4:0];
		d.stim.match_word = word;
		d.stim.contender = cont[6:0];
		d.stim.last_contender = last;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	function automatic item_t next_item(bit focus);
		item_t it;
		logic [63:0] raw;
		int pick;
		raw = {$urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		if (bracket_left > 0 && $urandom_range(0, 99) < 85) begin
			it.mode = MODE_CONTEND;
			bracket_left--;
			it.last_contender = (bracket_left == 0);
			return it;
		end
		pick = $urandom_range(0, 99);
		if (pick < (focus ? 0 : 3)) begin
			it.mode = MODE_CLEAR;
		end else if (pick < 48) begin
			it.mode = MODE_TALLY;
			if (focus) begin
				it.group = 5'($urandom_range(0, 1));
				if ($urandom_range(0, 1) == 0) it.match_word = '1;
			end else begin
				case ($urandom_range(0, 4))
					0: it.match_word = '0;
					1: it.match_word = '1;
					2: it.match_word = $urandom & $urandom & $urandom;
					default: ;
				endcase
			end
		end else if (pick < 60) begin
			it.mode = MODE_REPORT;
		end else if (pick < 92) begin
			it.mode = MODE_CONTEND;
			bracket_left = $urandom_range(0, 4);
			it.last_contender = (bracket_left == 0);
		end else begin
			it.mode = MODE_CONTEND;
		end
		return it;
	endfunction

	function automatic string show(result_t r);
		return $sformatf("kind=%0d fittest=%0d/%0d least=%0d/%0d avg=%0d solved=%0d winner=%0d",
			r.kind, r.fittest_index, r.fittest_score, r.least_index, r.least_score,
			r.average_score, r.solved, r.winner_index);
	endfunction

	task automatic note_failure(string what);
		failures++;
		if (failures <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// one input transaction, with an optional idle burst ahead of it
	task automatic offer(item_t it, bit typed, result_t want);
		result_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_valid <= 1'b1;
		offered <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
		if (tally_rank(it, r)) awaited_results.push_back(typed ? want : r);
	endtask

	task automatic write_target(logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		target = value;
		settings_written++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result transaction checker
	always @(posedge clk) begin : result_check
		result_t want;
		string diff;
		if (arst_n && result_valid && !result_stall) begin
			if (result.kind == KIND_WINNER) winners_seen++;
			else reports_seen++;
			if (result.kind == KIND_REPORT && result.solved) solved_seen++;
			if (result.kind == KIND_REPORT && result.fittest_score == SCORE_MAX) saturated_seen++;
			if (awaited_results.size() == 0) begin
				note_failure({"unexpected result ", show(result)});
			end else begin
				want = awaited_results.pop_front();
				diff = "";
				if (result.kind !== want.kind) diff = {diff, " kind"};
				if (result.fittest_index !== want.fittest_index) diff = {diff, " fittest_index"};
				if (result.fittest_score !== want.fittest_score) diff = {diff, " fittest_score"};
				if (result.least_index !== want.least_index) diff = {diff, " least_index"};
				if (result.least_score !== want.least_score) diff = {diff, " least_score"};
				if (result.average_score !== want.average_score) diff = {diff, " average_score"};
				if (result.solved !== want.solved) diff = {diff, " solved"};
				if (result.winner_index !== want.winner_index) diff = {diff, " winner_index"};
				if (diff != "")
					note_failure({"fields", diff, "\n  expected ", show(want),
						"\n  actual   ", show(result)});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("ga_fitness_tally_tournament verification failed");
			$finish;
		end
	end

	// output side: short random stalls, one long hold on request
	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : sender
		drill_t drills [$];
		result_t zero_rep;
		result_t rep16;
		result_t win127;
		result_t win0;
		logic [7:0] setting;

		foreach (fitness[p]) fitness[p] = '0;
		champion = 0;
		bracket_open = 1'b0;
		target = TARGET_RESET;

		zero_rep = '0;
		rep16 = '0;
		rep16.fittest_score = 8'd16;
		rep16.least_index = 7'd4;
		rep16.solved = 1'b1;
		win127 = '0;
		win127.kind = KIND_WINNER;
		win127.winner_index = 7'd127;
		win0 = '0;
		win0.kind = KIND_WINNER;

		drills.push_back(drill(MODE_REPORT, 0, 32'h0, 0, 1'b0, 1'b1, zero_rep));
		drills.push_back(drill(MODE_CONTEND, 0, 32'h0, 127, 1'b1, 1'b1, win127));
		drills.push_back(drill(MODE_CONTEND, 31, '1, 0, 1'b1, 1'b1, win0));
		drills.push_back(drill(MODE_TALLY, 0, '1, 0, 1'b0));
		drills.push_back(drill(MODE_TALLY, 0, '1, 127, 1'b1));
		// reset target of 16 reached by the first four scores
		drills.push_back(drill(MODE_REPORT, 0, 32'h0, 0, 1'b0, 1'b1, rep16));
		drills.push_back(drill(MODE_TALLY, 31, '1, 0, 1'b0));
		drills.push_back(drill(MODE_TALLY, 31, 32'h0, 127, 1'b1));
		drills.push_back(drill(MODE_TALLY, 5, 32'h8040_2001, 0, 1'b0));
		drills.push_back(drill(MODE_REPORT, 31, '1, 127, 1'b1));
		drills.push_back(drill(MODE_CONTEND, 0, 32'h0, 20, 1'b0));
		drills.push_back(drill(MODE_CONTEND, 0, 32'h0, 124, 1'b0));
		drills.push_back(drill(MODE_CONTEND, 0, 32'h0, 4, 1'b0));
		drills.push_back(drill(MODE_CONTEND, 0, 32'h0, 0, 1'b1));
		// clear in the middle of a tournament keeps it open
		drills.push_back(drill(MODE_CONTEND, 0, 32'h0, 21, 1'b0));
		drills.push_back(drill(MODE_CLEAR, 31, '1, 127, 1'b1));
		drills.push_back(drill(MODE_CONTEND, 0, 32'h0, 22, 1'b1));
		drills.push_back(drill(MODE_REPORT, 31, '1, 127, 1'b1, 1'b1, zero_rep));
		drills.push_back(drill(MODE_TALLY, 2, 32'h0F0F_0F0F, 127, 1'b1));
		drills.push_back(drill(MODE_CONTEND, 31, '1, 127, 1'b0));
		drills.push_back(drill(MODE_CONTEND, 31, '1, 9, 1'b1));
		drills.push_back(drill(MODE_REPORT, 0, 32'h0, 0, 1'b0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (drills[i]) offer(drills[i].stim, drills[i].typed, drills[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: setting = 8'd255;
				1: setting = 8'd0;
				2: setting = 8'd255;
				4: setting = 8'($urandom_range(1, 254));
				default: setting = peak_score();
			endcase
			write_target(setting);
			if (ph == 0) hold_req = 1'b1;
			if (ph == PHASES - 1) quiet = 1'b1;
			repeat (PHASE_ITEMS) offer(next_item(ph == 2), 1'b0, '0);
		end

		drain();
		$display("run covered %0d items over %0d target settings, with one long output hold",
			items_sent, settings_written);
		$display("results: %0d reports (%0d solved, %0d with a saturated score), %0d winners",
			reports_seen, solved_seen, saturated_seen, winners_seen);
		if (failures == 0 && awaited_results.size() == 0) begin
			$display("ga_fitness_tally_tournament verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", failures, awaited_results.size());
			$display("ga_fitness_tally_tournament verification failed");
		end
		$finish;
	end

endmodule
